[hw/rtl/rob_pkg.sv]
// Reorder buffer package: window sizing, item structs, drop status codes and
// the command and status groups between controller and datapath. No dependencies.
package rob_pkg;

	localparam int WINDOW     = 64;
	localparam int VALUE_BITS = 64;
	localparam int SLOT_W     = $clog2(WINDOW);
	localparam int SEQ_W      = 32;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [1:0] {
		ST_RELEASED = 2'd0,
		ST_STALE    = 2'd1,
		ST_BEYOND   = 2'd2,
		ST_DUP      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_STORE,
		CLS_STALE,
		CLS_BEYOND,
		CLS_DUP
	} cls_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_index;
		logic [63:0]      item_value;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_value;
		logic        run_last;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic store;
		logic load_drop;
		logic load_rel;
		logic rd_next;
	} ctrl_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic is_head;
		logic out_free;
		logic next_valid;
	} dp_stat_t;

endpackage

[hw/rtl/in_order_release_reorder_buffer_core.sv]
// Reorder buffer top level: joins the controller and the datapath.
// Depends on rob_pkg, rob_ctrl and rob_datapath.
//
// Takes (seq_index, item_value) items in any order and releases values in index
// order through a 64-slot window. An item that is parked or dropped occupies the
// input while it is accepted and then classified against the window. An item
// that completes a run is followed by a first read of the value memory, then
// releases one value per cycle while out_stall is low. The single-port read of
// the value memory sets the release rate. A dropped item yields one result with
// its drop status and zero value; run_last marks the final result caused by
// each item.
module in_order_release_reorder_buffer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rob_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output rob_pkg::out_item_t  out_item
);
	import rob_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rob_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rob_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

[hw/rtl/rob_datapath.sv]
// Reorder buffer datapath: index offset, slot classification, slot valid bits,
// value memory, head pointers and the output register. Depends on rob_pkg.
module rob_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rob_pkg::in_item_t    in_item,
	input  logic                 out_stall,
	output logic                 out_valid,
	output rob_pkg::out_item_t   out_item,
	input  rob_pkg::ctrl_cmd_t   cmd,
	output rob_pkg::dp_stat_t    stat
);
	import rob_pkg::*;

	logic [SEQ_W-1:0]      next_expected_q;
	slot_t                 head_q;
	logic [WINDOW-1:0]     valid_q;
	logic [SEQ_W-1:0]      d_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] mem [WINDOW];
	logic [VALUE_BITS-1:0] rd_data_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  stale;
	logic                  beyond;
	logic [SLOT_W:0]       slot_sum;
	logic [SLOT_W:0]       slot_wrap;
	slot_t                 slot;
	slot_t                 head_inc;
	slot_t                 rd_addr;
	cls_t                  cls;
	status_t               drop_status;

	always_comb begin
		stale     = d_q[SEQ_W-1];
		beyond    = d_q >= SEQ_W'(WINDOW);
		slot_sum  = {1'b0, head_q} + {1'b0, d_q[SLOT_W-1:0]};
		slot_wrap = slot_sum - (SLOT_W+1)'(WINDOW);
		if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
			slot = slot_wrap[SLOT_W-1:0];
		end else begin
			slot = slot_sum[SLOT_W-1:0];
		end
		if (head_q == SLOT_W'(WINDOW - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + SLOT_W'(1);
		end
		if (stale) begin
			cls = CLS_STALE;
		end else if (beyond) begin
			cls = CLS_BEYOND;
		end else if (valid_q[slot]) begin
			cls = CLS_DUP;
		end else begin
			cls = CLS_STORE;
		end
		unique case (cls)
			CLS_STALE:  drop_status = ST_STALE;
			CLS_BEYOND: drop_status = ST_BEYOND;
			CLS_DUP:    drop_status = ST_DUP;
			default:    drop_status = ST_RELEASED;
		endcase
		rd_addr = cmd.rd_next ? head_inc : head_q;
	end

	assign stat.cls        = cls;
	assign stat.is_head    = d_q == '0;
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.next_valid = valid_q[head_inc];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_expected_q <= '0;
			head_q          <= '0;
			valid_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.store) begin
				valid_q[slot] <= 1'b1;
			end
			if (cmd.load_rel) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_inc;
				next_expected_q <= next_expected_q + SEQ_W'(1);
			end
			if (cmd.load_drop || cmd.load_rel) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			d_q   <= in_item.seq_index - next_expected_q;
			val_q <= in_item.item_value[VALUE_BITS-1:0];
		end
		if (cmd.store) begin
			mem[slot] <= val_q;
		end
		rd_data_q <= mem[rd_addr];
		if (cmd.load_drop) begin
			out_q.out_value <= '0;
			out_q.run_last  <= 1'b1;
			out_q.status    <= drop_status;
		end else if (cmd.load_rel) begin
			out_q.out_value <= 64'(rd_data_q);
			out_q.run_last  <= !valid_q[head_inc];
			out_q.status    <= ST_RELEASED;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[hw/rtl/rob_ctrl.sv]
// Reorder buffer controller: sequences accept, classify, slot read and run release.
// Depends on rob_pkg.
module rob_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rob_pkg::dp_stat_t    stat,
	output rob_pkg::ctrl_cmd_t   cmd
);
	import rob_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.cls == CLS_STORE) begin
						state_q <= stat.is_head ? S_READ : S_IDLE;
					end else if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free && !stat.next_valid) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_stall      = state_q != S_IDLE;
		cmd.capture   = state_q == S_IDLE && in_valid;
		cmd.store     = state_q == S_CHECK && stat.cls == CLS_STORE;
		cmd.load_drop = state_q == S_CHECK && stat.cls != CLS_STORE && stat.out_free;
		cmd.load_rel  = state_q == S_EMIT && stat.out_free;
		cmd.rd_next   = cmd.load_rel;
	end

endmodule
